### hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths, types and state codes for the modular exponentiation unit
// ----------------------------------------------------------------------------
package mexp_pkg;

    // operand widths
    localparam int DATA_W = 31;
    localparam int EXP_W  = 63;
    localparam int CNT_W  = $clog2(DATA_W);

    // request to the modular multiplier
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] m;
    } t_mul_req;

    // response from the modular multiplier
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_mul_rsp;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MULT,
        ST_SQUARE,
        ST_OUT
    } t_state;

endpackage

### hdl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial interleaved modular multiplier: a * b mod m, b scanned msb first
// ----------------------------------------------------------------------------
module mexp_mulmod (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mexp_pkg::t_mul_req   i_req,
    output mexp_pkg::t_mul_rsp   o_rsp
);

    logic [mexp_pkg::DATA_W-1:0] r_a;
    logic [mexp_pkg::DATA_W-1:0] r_b;
    logic [mexp_pkg::DATA_W-1:0] r_m;
    logic [mexp_pkg::DATA_W-1:0] r_acc;
    logic [mexp_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_phase;
    logic                        r_busy;
    logic                        r_done;

    logic [mexp_pkg::DATA_W:0]   w_sum;
    logic [mexp_pkg::DATA_W:0]   w_red;
    logic [mexp_pkg::DATA_W-1:0] n_acc;

    // phase 0 doubles the partial result, phase 1 adds a when the b bit is set;
    // a zero modulus wraps modulo 2^31 instead of subtracting
    always_comb begin
        if (!r_phase) begin
            w_sum = {r_acc, 1'b0};
        end else begin
            w_sum = {1'b0, r_acc} + (r_b[mexp_pkg::DATA_W-1] ? {1'b0, r_a} : '0);
        end
        if ((r_m != '0) && (w_sum >= {1'b0, r_m})) begin
            w_red = w_sum - {1'b0, r_m};
        end else begin
            w_red = w_sum;
        end
        n_acc = w_red[mexp_pkg::DATA_W-1:0];
    end

    // operand registers and iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a     <= i_req.a;
                r_b     <= i_req.b;
                r_m     <= i_req.m;
                r_acc   <= '0;
                r_cnt   <= '0;
                r_phase <= 1'b0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_acc   <= n_acc;
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_b   <= {r_b[mexp_pkg::DATA_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == mexp_pkg::CNT_W'(mexp_pkg::DATA_W - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

### hdl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base ^ exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// One word in gives one word out. All modular products go through a single
// bit-serial multiplier that spends a doubling phase and an adding phase on
// each multiplier bit. An item first reduces the base (one multiplication),
// then for each exponent bit up to the highest set bit passes through the step
// state, performs a multiply when the bit is set and a squaring for every bit
// below the highest one. A zero exponent skips the multiplier and goes straight
// to the output state. While the output register still holds an unaccepted
// word the finished result waits; the unit takes the next word only after the
// result has moved to the output register.
module modular_exponentiation_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side tdata: base_value[30:0], exponent[93:31], modulus[124:94]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    // master side tdata: power_result[30:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata
);

    localparam int DW = mexp_pkg::DATA_W;
    localparam int EW = mexp_pkg::EXP_W;

    mexp_pkg::t_state   r_state, n_state;
    mexp_pkg::t_mul_req r_req, n_req;
    mexp_pkg::t_mul_rsp w_rsp;

    logic [DW-1:0] r_base, n_base;
    logic [DW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_mod, n_mod;
    logic [EW-1:0] r_exp, n_exp;
    logic [DW-1:0] r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic [DW-1:0] w_in_base;
    logic [EW-1:0] w_in_exp;
    logic [DW-1:0] w_in_mod;
    logic [DW-1:0] w_one;
    logic          w_in_take;
    logic          w_out_free;

    // unpack the input word
    assign w_in_base = s_axis_tdata[DW-1:0];
    assign w_in_exp  = s_axis_tdata[DW+EW-1:DW];
    assign w_in_mod  = s_axis_tdata[2*DW+EW-1:DW+EW];

    // one reduced by the modulus: zero when the modulus is one
    assign w_one = (w_in_mod == DW'(1)) ? '0 : DW'(1);

    assign s_axis_tready = (r_state == mexp_pkg::ST_IDLE);
    assign w_in_take     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // shared modular multiplier
    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_req.start = 1'b0;
        n_base      = r_base;
        n_acc       = r_acc;
        n_mod       = r_mod;
        n_exp       = r_exp;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (w_in_take) begin
                    n_mod = w_in_mod;
                    n_exp = w_in_exp;
                    n_acc = DW'(1);
                    if (w_in_exp == '0) begin
                        // zero exponent answers 1 unreduced
                        n_state = mexp_pkg::ST_OUT;
                    end else begin
                        // reduce the base as one times base
                        n_acc       = w_one;
                        n_req.start = 1'b1;
                        n_req.a     = w_one;
                        n_req.b     = w_in_base;
                        n_req.m     = w_in_mod;
                        n_state     = mexp_pkg::ST_REDUCE;
                    end
                end
            end
            mexp_pkg::ST_REDUCE: begin
                if (w_rsp.done) begin
                    n_base  = w_rsp.result;
                    n_state = mexp_pkg::ST_STEP;
                end
            end
            mexp_pkg::ST_STEP: begin
                n_req.start = 1'b1;
                n_req.m     = r_mod;
                if (r_exp[0]) begin
                    n_req.a = r_acc;
                    n_req.b = r_base;
                    n_state = mexp_pkg::ST_MULT;
                end else begin
                    n_req.a = r_base;
                    n_req.b = r_base;
                    n_state = mexp_pkg::ST_SQUARE;
                end
            end
            mexp_pkg::ST_MULT: begin
                if (w_rsp.done) begin
                    n_acc = w_rsp.result;
                    if (r_exp[EW-1:1] == '0) begin
                        n_state = mexp_pkg::ST_OUT;
                    end else begin
                        n_req.start = 1'b1;
                        n_req.a     = r_base;
                        n_req.b     = r_base;
                        n_req.m     = r_mod;
                        n_state     = mexp_pkg::ST_SQUARE;
                    end
                end
            end
            mexp_pkg::ST_SQUARE: begin
                if (w_rsp.done) begin
                    n_base  = w_rsp.result;
                    n_exp   = {1'b0, r_exp[EW-1:1]};
                    n_state = mexp_pkg::ST_STEP;
                end
            end
            mexp_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = mexp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // state, multiplier request and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mexp_pkg::ST_IDLE;
            r_req       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req       <= n_req;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_acc   <= n_acc;
        r_mod   <= n_mod;
        r_exp   <= n_exp;
        r_out   <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

endmodule

### tb/sv/modular_exponentiation_unit_tb.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_tb
// self-checking bench for base ^ exponent mod modulus
// ----------------------------------------------------------------------------
// A short table of directed words covers the operand extremes: zero exponent,
// a full 63-bit exponent, an unreduced base and a zero modulus. A random run
// follows in four traffic phases: quiet, sender gaps, receiver stalls and
// both. Every accepted word gets its expected power, typed in or from a
// square-and-multiply predictor. Each output word is compared in order to it.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = mexp_pkg::DATA_W;
    localparam int EXP_W  = mexp_pkg::EXP_W;

    // traffic phases of the random run
    typedef enum int {
        PH_QUIET,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH
    } t_phase;

    // one directed row; power is typed in only where known at a glance
    typedef struct packed {
        logic [DATA_W-1:0] base_value;
        logic [EXP_W-1:0]  exponent;
        logic [DATA_W-1:0] modulus;
        logic              typed;
        logic [DATA_W-1:0] power;
    } t_vector;

    localparam int                NUM_DIRECTED  = 18;
    localparam int                WORDS_PER_PH  = 25;
    localparam int                DRAIN_CYCLES  = 200;
    localparam logic [DATA_W-1:0] DATA_MAX      = {DATA_W{1'b1}};
    localparam logic [EXP_W-1:0]  EXP_MAX       = {EXP_W{1'b1}};

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;

    logic [DATA_W-1:0] pending_powers[$];
    logic [DATA_W-1:0] want_power;
    int                fail_count     = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    t_vector           directed_vectors [NUM_DIRECTED];

    // random stimulus scratch
    logic [DATA_W-1:0] rnd_base;
    logic [EXP_W-1:0]  rnd_exp;
    logic [DATA_W-1:0] rnd_mod;
    int                pick;

    modular_exponentiation_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // a * b mod m, wrapping to 31 bits when the modulus is zero
    function automatic logic [DATA_W-1:0] mod_product(input logic [DATA_W-1:0] a,
                                                      input logic [DATA_W-1:0] b,
                                                      input logic [DATA_W-1:0] m);
        logic [63:0] prod;
        logic [63:0] rem;
        prod = {33'd0, a} * {33'd0, b};
        rem  = (m == '0) ? prod : prod % {33'd0, m};
        return rem[DATA_W-1:0];
    endfunction

    // right-to-left square-and-multiply; zero exponent leaves the 1 unreduced
    function automatic logic [DATA_W-1:0] expected_power(input logic [DATA_W-1:0] b,
                                                         input logic [EXP_W-1:0]  e,
                                                         input logic [DATA_W-1:0] m);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] sq;
        logic [EXP_W-1:0]  rest;
        acc  = DATA_W'(1);
        sq   = b;
        rest = e;
        while (rest != '0) begin
            if (rest[0]) begin
                acc = mod_product(acc, sq, m);
            end
            sq   = mod_product(sq, sq, m);
            rest = rest >> 1;
        end
        return acc;
    endfunction

    task automatic set_phase(input t_phase ph);
        case (ph)
            PH_QUIET: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PH_SENDER_IDLE: begin
                send_idle_pct  = 76;
                recv_stall_pct = 0;
            end
            PH_RECEIVER_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 76;
            end
            default: begin
                send_idle_pct  = 33;
                recv_stall_pct = 33;
            end
        endcase
    endtask

    // hold off until every expected word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_powers.size() != 0);
    endtask

    // offer one word, wait for the handshake, then record its expected power
    task automatic send_word(input logic [DATA_W-1:0] b,
                             input logic [EXP_W-1:0]  e,
                             input logic [DATA_W-1:0] m,
                             input logic              typed,
                             input logic [DATA_W-1:0] power);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, m, e, b};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_powers.insert(pending_powers.size(),
                              typed ? power : expected_power(b, e, m));
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_powers.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h",
                         $time, m_axis_tdata[DATA_W-1:0]);
                fail_count++;
            end else begin
                want_power = pending_powers.pop_front();
                if (m_axis_tdata[DATA_W-1:0] !== want_power) begin
                    $display("%0t: power_result mismatch, expected %h, actual %h",
                             $time, want_power, m_axis_tdata[DATA_W-1:0]);
                    fail_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        directed_vectors = '{
            // zero exponent gives 1 even with modulus 1
            '{31'd0,     63'd0,      31'd1,       1'b1, 31'd1},
            '{DATA_MAX,  63'd0,      DATA_MAX,    1'b1, 31'd1},
            '{31'd0,     63'd0,      31'd0,       1'b1, 31'd1},
            // unreduced base gets reduced by the first multiply
            '{DATA_MAX,  63'd1,      DATA_MAX,    1'b1, 31'd0},
            '{DATA_MAX,  63'd1,      31'd1,       1'b1, 31'd0},
            '{31'd0,     63'd1,      DATA_MAX,    1'b1, 31'd0},
            '{31'd5,     63'd1,      31'd7,       1'b1, 31'd5},
            '{31'd2,     63'd10,     DATA_MAX,    1'b1, 31'd1024},
            '{31'd1000,  63'd3,      31'd1,       1'b1, 31'd0},
            // full-width and single top-bit exponents
            '{31'd3,     EXP_MAX,    DATA_MAX,    1'b0, 31'd0},
            '{31'd1,     63'h4000_0000_0000_0000, DATA_MAX, 1'b1, 31'd1},
            '{31'd12345, 63'h5555_5555_5555_5555, 31'd1000000007, 1'b0, 31'd0},
            '{31'h2AAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA, 31'h5555_5555, 1'b0, 31'd0},
            '{DATA_MAX - 31'd1, 63'd2, DATA_MAX,  1'b0, 31'd0},
            '{DATA_MAX,  63'd2,      31'h4000_0000, 1'b0, 31'd0},
            // zero modulus wraps products to 31 bits
            '{DATA_MAX,  EXP_MAX,    31'd0,       1'b0, 31'd0},
            '{31'd2,     63'd31,     31'd0,       1'b1, 31'd0},
            '{31'd7,     63'd1,      31'd0,       1'b1, 31'd7}
        };

        set_phase(PH_QUIET);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_word(directed_vectors[i].base_value, directed_vectors[i].exponent,
                      directed_vectors[i].modulus, directed_vectors[i].typed,
                      directed_vectors[i].power);
        end

        // random words, phase by phase, draining in between
        for (int ph = PH_QUIET; ph <= PH_BOTH; ph++) begin
            drain_results();
            set_phase(t_phase'(ph));
            for (int n = 0; n < WORDS_PER_PH; n++) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    rnd_base = DATA_W'($urandom_range(15));
                end else if (pick < 15) begin
                    rnd_base = DATA_MAX;
                end else begin
                    rnd_base = DATA_W'($urandom);
                end

                // mostly short exponents, a few full width
                rnd_exp = EXP_W'({$urandom, $urandom});
                pick    = $urandom_range(99);
                if (pick < 5) begin
                    rnd_exp = '0;
                end else if (pick >= 15) begin
                    rnd_exp = rnd_exp & ((63'd1 << $urandom_range(12, 1)) - 63'd1);
                end

                pick = $urandom_range(99);
                if (pick < 3) begin
                    rnd_mod = '0;
                end else if (pick < 13) begin
                    rnd_mod = DATA_W'($urandom_range(16, 1));
                end else if (pick < 18) begin
                    rnd_mod = DATA_MAX;
                end else begin
                    rnd_mod = DATA_W'($urandom_range(32'h7FFF_FFFF, 1));
                end

                send_word(rnd_base, rnd_exp, rnd_mod, 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_powers.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, pending_powers.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
